// File: rtl/ppq_pkg.sv
// ppq_pkg: shared types, constants and palette tables for the pixel palette quantizer
// no dependencies; used by ppq_if.sv and pixel_palette_quantizer.sv

package ppq_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned DigitW  = 3;
  localparam int unsigned GrayW   = 6;
  localparam int unsigned SqW     = 2 * ChanW;
  localparam int unsigned DistW   = SqW + 2;

  localparam logic [IdxW-1:0]   FirstIdx    = 8'd1;
  localparam logic [IdxW-1:0]   CubeLastIdx = 8'd216;
  localparam logic [IdxW-1:0]   LastIdx     = 8'd255;
  localparam logic [DigitW-1:0] DigitMax    = 3'd5;
  localparam logic [CodeW-1:0]  CodeClear   = 16'h0000;

  // output_mode register codes
  localparam logic MODE_INDEX  = 1'b0;
  localparam logic MODE_RGB565 = 1'b1;

  typedef enum logic [1:0] {
    PPQ_IDLE,
    PPQ_SEARCH,
    PPQ_DONE
  } ppq_state_e;

  typedef struct packed {
    logic in_ready;
    logic start;
    logic step;
    logic load_out;
  } ppq_ctrl_t;

  // cube level for one digit: digit * 51
  function automatic logic [ChanW-1:0] cube_level(input logic [DigitW-1:0] digit);
    logic [ChanW-1:0] lvl;
    unique case (digit)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd51;
      3'd2:    lvl = 8'd102;
      3'd3:    lvl = 8'd153;
      3'd4:    lvl = 8'd204;
      3'd5:    lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

  // gray ramp: floor(k * 255 / 38)
  function automatic logic [ChanW-1:0] gray_level(input logic [GrayW-1:0] k);
    logic [ChanW-1:0] lvl;
    unique case (k)
      6'd0:  lvl = 8'd0;    6'd1:  lvl = 8'd6;    6'd2:  lvl = 8'd13;
      6'd3:  lvl = 8'd20;   6'd4:  lvl = 8'd26;   6'd5:  lvl = 8'd33;
      6'd6:  lvl = 8'd40;   6'd7:  lvl = 8'd46;   6'd8:  lvl = 8'd53;
      6'd9:  lvl = 8'd60;   6'd10: lvl = 8'd67;   6'd11: lvl = 8'd73;
      6'd12: lvl = 8'd80;   6'd13: lvl = 8'd87;   6'd14: lvl = 8'd93;
      6'd15: lvl = 8'd100;  6'd16: lvl = 8'd107;  6'd17: lvl = 8'd114;
      6'd18: lvl = 8'd120;  6'd19: lvl = 8'd127;  6'd20: lvl = 8'd134;
      6'd21: lvl = 8'd140;  6'd22: lvl = 8'd147;  6'd23: lvl = 8'd154;
      6'd24: lvl = 8'd161;  6'd25: lvl = 8'd167;  6'd26: lvl = 8'd174;
      6'd27: lvl = 8'd181;  6'd28: lvl = 8'd187;  6'd29: lvl = 8'd194;
      6'd30: lvl = 8'd201;  6'd31: lvl = 8'd208;  6'd32: lvl = 8'd214;
      6'd33: lvl = 8'd221;  6'd34: lvl = 8'd228;  6'd35: lvl = 8'd234;
      6'd36: lvl = 8'd241;  6'd37: lvl = 8'd248;  6'd38: lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

  function automatic logic [SqW-1:0] sq_diff(input logic [ChanW-1:0] a,
                                             input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

// File: rtl/ppq_if.sv
// ppq_if: valid/ready channel interfaces for pixel beats in and code beats out
// depends on ppq_pkg for field widths

interface ppq_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [ppq_pkg::ChanW-1:0] red;
  logic [ppq_pkg::ChanW-1:0] green;
  logic [ppq_pkg::ChanW-1:0] blue;
  logic [ppq_pkg::ChanW-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface ppq_code_if;
  logic                      valid;
  logic                      ready;
  logic [ppq_pkg::CodeW-1:0] pixel_code;

  modport source (output valid, pixel_code, input ready);
  modport sink   (input valid, pixel_code, output ready);
endinterface

// File: rtl/pixel_palette_quantizer.sv
// pixel_palette_quantizer: rgba8888 pixel to palette index or rgb565 word
// depends on ppq_pkg and the channel interfaces in ppq_if.sv
//
//  channel   dir  payload                        handshake
//  pix_i     in   red, green, blue, alpha        valid/ready
//  code_o    out  pixel_code[15:0]               valid/ready
//  cfg       in   cfg_wdata_i (output_mode)      cfg_we_i, no ready
//
//  palette mode: a search over all 255 palette entries (one palette entry per cycle
//  through the shared distance unit), then a hand-off to the output register; the
//  next pixel is accepted after that. rgb565 mode or zero alpha: accept, then hand off.
//  a finished code sits in the output register, so the next pixel can be taken
//  while code_o is stalled; the search end waits only if that register is full.
//  rst_ni clears the sequencer, the output valid and output_mode.

module pixel_palette_quantizer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  ppq_pixel_if.sink        pix_i,
  ppq_code_if.source       code_o
);

  ppq_pkg::ppq_state_e state_q, state_d;
  ppq_pkg::ppq_ctrl_t  ctrl;

  logic mode_q;
  logic out_valid_q, out_valid_d;

  logic [ppq_pkg::ChanW-1:0]  red_q, green_q, blue_q;
  logic [ppq_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [ppq_pkg::DigitW-1:0] dr_q, dr_d, dg_q, dg_d, db_q, db_d;
  logic [ppq_pkg::GrayW-1:0]  k_q, k_d;
  logic [ppq_pkg::DistW-1:0]  best_dist_q, best_dist_d;
  logic [ppq_pkg::IdxW-1:0]   best_idx_q, best_idx_d;
  logic [ppq_pkg::CodeW-1:0]  result_q, result_d;
  logic [ppq_pkg::CodeW-1:0]  out_code_q;

  logic                       accept;
  logic                       direct;
  logic                       in_cube;
  logic                       better;
  logic                       last;
  logic [ppq_pkg::ChanW-1:0]  pal_r, pal_g, pal_b, gray;
  logic [ppq_pkg::DistW-1:0]  cand_dist;
  logic [ppq_pkg::IdxW-1:0]   win_idx;
  logic [ppq_pkg::CodeW-1:0]  direct_code;

  assign accept = pix_i.valid && ctrl.in_ready;
  assign direct = (pix_i.alpha == '0) || (mode_q == ppq_pkg::MODE_RGB565);
  assign last   = (idx_q == ppq_pkg::LastIdx);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppq_pkg::PPQ_IDLE: begin
        if (accept) begin
          state_d = direct ? ppq_pkg::PPQ_DONE : ppq_pkg::PPQ_SEARCH;
        end
      end
      ppq_pkg::PPQ_SEARCH: begin
        if (last) begin
          state_d = ppq_pkg::PPQ_DONE;
        end
      end
      ppq_pkg::PPQ_DONE: begin
        if (!out_valid_q || code_o.ready) begin
          state_d = ppq_pkg::PPQ_IDLE;
        end
      end
      default: state_d = ppq_pkg::PPQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ppq_pkg::PPQ_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.start    = pix_i.valid;
      end
      ppq_pkg::PPQ_SEARCH: begin
        ctrl.step = 1'b1;
      end
      ppq_pkg::PPQ_DONE: begin
        ctrl.load_out = !out_valid_q || code_o.ready;
      end
      default: ctrl = '0;
    endcase
  end

  // shared distance unit: one palette entry per cycle
  assign in_cube   = (idx_q <= ppq_pkg::CubeLastIdx);
  assign gray      = ppq_pkg::gray_level(k_q);
  assign pal_r     = in_cube ? ppq_pkg::cube_level(dr_q) : gray;
  assign pal_g     = in_cube ? ppq_pkg::cube_level(dg_q) : gray;
  assign pal_b     = in_cube ? ppq_pkg::cube_level(db_q) : gray;
  assign cand_dist = {2'b00, ppq_pkg::sq_diff(red_q, pal_r)}
                   + {2'b00, ppq_pkg::sq_diff(green_q, pal_g)}
                   + {2'b00, ppq_pkg::sq_diff(blue_q, pal_b)};
  assign better    = (cand_dist < best_dist_q);
  assign win_idx   = better ? idx_q : best_idx_q;

  assign direct_code = (pix_i.alpha == '0) ? ppq_pkg::CodeClear
                     : {pix_i.red[7:3], pix_i.green[7:2], pix_i.blue[7:3]};

  always_comb begin
    idx_d       = idx_q;
    dr_d        = dr_q;
    dg_d        = dg_q;
    db_d        = db_q;
    k_d         = k_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    result_d    = result_q;
    if (ctrl.start) begin
      idx_d       = ppq_pkg::FirstIdx;
      dr_d        = '0;
      dg_d        = '0;
      db_d        = '0;
      k_d         = '0;
      best_dist_d = '1;
      best_idx_d  = ppq_pkg::FirstIdx;
      result_d    = direct_code;
    end else if (ctrl.step) begin
      best_idx_d = win_idx;
      if (better) begin
        best_dist_d = cand_dist;
      end
      result_d = {{(ppq_pkg::CodeW - ppq_pkg::IdxW){1'b0}}, win_idx};
      idx_d    = idx_q + 1'b1;
      if (in_cube) begin
        // odometer over the three cube digits, blue fastest
        if (db_q == ppq_pkg::DigitMax) begin
          db_d = '0;
          if (dg_q == ppq_pkg::DigitMax) begin
            dg_d = '0;
            dr_d = dr_q + 1'b1;
          end else begin
            dg_d = dg_q + 1'b1;
          end
        end else begin
          db_d = db_q + 1'b1;
        end
      end else begin
        k_d = k_q + 1'b1;
      end
    end
  end

  assign out_valid_d = ctrl.load_out || (out_valid_q && !code_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppq_pkg::PPQ_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= ppq_pkg::MODE_INDEX;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
    end
    idx_q       <= idx_d;
    dr_q        <= dr_d;
    dg_q        <= dg_d;
    db_q        <= db_d;
    k_q         <= k_d;
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    result_q    <= result_d;
    if (ctrl.load_out) begin
      out_code_q <= result_q;
    end
  end

  assign pix_i.ready       = ctrl.in_ready;
  assign code_o.valid      = out_valid_q;
  assign code_o.pixel_code = out_code_q;

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for pixel_palette_quantizer, rgba pixels in, codes out
// depends on ppq_pkg, ppq_if.sv (ppq_pixel_if, ppq_code_if) and the quantizer rtl
// a scoreboard class predicts each code from the accepted pixel and the output mode
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned HoldCycles  = 8;
  localparam int unsigned SegItems    = 183;
  localparam int unsigned MaxPrinted  = 20;

  typedef struct packed {
    logic [ppq_pkg::ChanW-1:0] red;
    logic [ppq_pkg::ChanW-1:0] green;
    logic [ppq_pkg::ChanW-1:0] blue;
    logic [ppq_pkg::ChanW-1:0] alpha;
  } pixel_t;

  class code_scoreboard;
    logic                      mode;
    logic [ppq_pkg::CodeW-1:0] expected_q[$];
    int unsigned               errors;
    int unsigned               checked;
    int unsigned               pixels;

    function new();
      mode    = ppq_pkg::MODE_INDEX;
      errors  = 0;
      checked = 0;
      pixels  = 0;
    endfunction

    function int unsigned sq_dist(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? (a - b) : (b - a);
      return d * d;
    endfunction

    // walk all 255 entries, the first strict minimum keeps the lowest index on a tie
    function logic [ppq_pkg::IdxW-1:0] nearest_entry(pixel_t p);
      int unsigned best_dist;
      int unsigned cand_dist;
      int unsigned er, eg, eb, n, lvl;
      logic [ppq_pkg::IdxW-1:0] best_idx;
      best_dist = 32'hffff_ffff;
      best_idx  = ppq_pkg::FirstIdx;
      for (int i = 1; i < 256; i++) begin
        if (i <= 216) begin
          n  = i - 1;
          er = (n / 36) * 51;
          eg = ((n / 6) % 6) * 51;
          eb = (n % 6) * 51;
        end else begin
          lvl = ((i - 217) * 255) / 38;
          er  = lvl;
          eg  = lvl;
          eb  = lvl;
        end
        cand_dist = sq_dist(32'(p.red), er) + sq_dist(32'(p.green), eg)
                  + sq_dist(32'(p.blue), eb);
        if (cand_dist < best_dist) begin
          best_dist = cand_dist;
          best_idx  = i[ppq_pkg::IdxW-1:0];
        end
      end
      return best_idx;
    endfunction

    function logic [ppq_pkg::CodeW-1:0] predict_code(pixel_t p);
      if (p.alpha == '0) return ppq_pkg::CodeClear;
      if (mode == ppq_pkg::MODE_RGB565) return {p.red[7:3], p.green[7:2], p.blue[7:3]};
      return {8'h00, nearest_entry(p)};
    endfunction

    function void note_pixel(pixel_t p);
      expected_q = {expected_q, predict_code(p)};
      pixels++;
    endfunction

    task report_mismatch(string msg);
      if (errors < MaxPrinted) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_code(logic [ppq_pkg::CodeW-1:0] got);
      logic [ppq_pkg::CodeW-1:0] want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("code %h with no pixel pending", got));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("pixel_code %h, predicted %h (mode %0d)", got, want, mode));
      end
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_wdata_i;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned cycles = 0;

  code_scoreboard codes = new();

  ppq_pixel_if pix_bus ();
  ppq_code_if  code_bus ();

  pixel_palette_quantizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_bus),
    .code_o      (code_bus)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes still due", cycles, codes.expected_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: random backpressure on the code channel
  always @(posedge clk_i) begin
    code_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // every code beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && code_bus.valid && code_bus.ready) codes.check_code(code_bus.pixel_code);
  end

  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.red   <= p.red;
    pix_bus.green <= p.green;
    pix_bus.blue  <= p.blue;
    pix_bus.alpha <= p.alpha;
    do @(posedge clk_i); while (!pix_bus.ready);
    codes.note_pixel(p);
  endtask

  // stop sending until every predicted code has come back
  task automatic drain_codes();
    pix_bus.valid <= 1'b0;
    while (codes.expected_q.size() != 0) @(posedge clk_i);
    repeat (HoldCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain_codes();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    codes.mode = m;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int unsigned kind;
    int unsigned g;
    p    = $urandom();
    kind = $urandom_range(99);
    if (kind < 10) begin
      p.alpha = '0;
    end else begin
      p.alpha = 8'($urandom_range(255, 1));
      if (kind < 15) p.alpha = 8'd1;
      else if (kind < 20) p.alpha = 8'd255;
    end
    // colors close to grays and cube levels stress ties and near ties
    if (kind >= 20 && kind < 35) begin
      g = $urandom_range(255);
      p.red   = g[7:0];
      p.green = 8'(g + $urandom_range(2));
      p.blue  = 8'(g - $urandom_range(2));
    end else if (kind >= 35 && kind < 45) begin
      p.red   = 8'($urandom_range(5) * 51 + $urandom_range(2) - 1);
      p.green = 8'($urandom_range(5) * 51 + $urandom_range(2) - 1);
      p.blue  = 8'($urandom_range(5) * 51 + $urandom_range(2) - 1);
    end
    return p;
  endfunction

  initial begin
    pixel_t index_dir[$];
    pixel_t rgb_dir[$];
    pix_bus.valid  = 1'b0;
    pix_bus.red    = '0;
    pix_bus.green  = '0;
    pix_bus.blue   = '0;
    pix_bus.alpha  = '0;
    code_bus.ready = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = ppq_pkg::MODE_INDEX;
    tx_idle_pct    = 9;
    rx_idle_pct    = 84;

    index_dir = '{
      '{8'd0,   8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd3,   8'd3,   8'd3,   8'd1},   '{8'd128, 8'd128, 8'd128, 8'd128},
      '{8'd10,  8'd200, 8'd90,  8'd0},   '{8'd255, 8'd0,   8'd0,   8'd127},
      '{8'd1,   8'd2,   8'd254, 8'd2},   '{8'd25,  8'd26,  8'd76,  8'd255},
      '{8'd51,  8'd102, 8'd153, 8'd204}, '{8'd240, 8'd241, 8'd242, 8'd64}
    };
    rgb_dir = '{
      '{8'd0,   8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd255, 8'd1},
      '{8'd200, 8'd100, 8'd50,  8'd0},   '{8'd7,   8'd3,   8'd7,   8'd255},
      '{8'd248, 8'd0,   8'd0,   8'd1},   '{8'd0,   8'd252, 8'd0,   8'd2},
      '{8'd0,   8'd0,   8'd248, 8'd3},   '{8'd170, 8'd85,  8'd170, 8'd85}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, transparency, a gray tie and the black/transparent overlap
    write_mode(ppq_pkg::MODE_INDEX);
    foreach (index_dir[i]) send_pixel(index_dir[i]);
    write_mode(ppq_pkg::MODE_RGB565);
    foreach (rgb_dir[i]) send_pixel(rgb_dir[i]);

    for (int ph = 0; ph < 3; ph++) begin
      unique case (ph)
        0: begin tx_idle_pct = 9;  rx_idle_pct = 84; end
        1: begin tx_idle_pct = 84; rx_idle_pct = 9;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        write_mode((seg == 0) ? ppq_pkg::MODE_INDEX : ppq_pkg::MODE_RGB565);
        for (int n = 0; n < SegItems; n++) begin
          if (n == SegItems / 2) drain_codes();
          send_pixel(random_pixel());
        end
      end
    end

    drain_codes();
    repeat (20) @(posedge clk_i);
    while (codes.expected_q.size() != 0)
      codes.report_mismatch($sformatf("code %h never came", codes.expected_q.pop_front()));

    $display("covered %0d pixels in palette and rgb565 modes under three idle mixes",
             codes.pixels);
    $display("%0d codes compared, %0d mismatches", codes.checked, codes.errors);
    if (codes.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
